// File: rtl/lrux_pkg.sv
// Shared types and constants of the LRU cache with entry expiry.
`default_nettype none

package lrux_pkg;

   // Fixed field widths.
   localparam int CMD_W  = 3;
   localparam int CAP_W  = 5;
   localparam int TIME_W = 32;
   localparam int CSR_W  = 32;
   localparam int CSR_INDEX_W = 1;

   // Register reset values.
   localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;
   localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd300;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY       = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_EXPIRY = 1'd1;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUT    = 3'd0,
      CMD_GET    = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_TICK   = 3'd4
   } lrux_cmd_type;

   // What a cell loads at the update edge.
   typedef enum logic [2:0] {
      MOVE_HOLD,
      MOVE_HEAD,
      MOVE_PREV,
      MOVE_NEXT,
      MOVE_CLEAR
   } lrux_move_type;

   // Lookup broadcast to every cell.
   typedef struct packed {
      logic              strobe;
      logic [TIME_W-1:0] time_now;
   } lrux_lookup_type;

   // Status a cell reports to the controller and its neighbors.
   typedef struct packed {
      logic valid;
      logic match;
      logic expired;
   } lrux_stat_type;

endpackage

`default_nettype wire

// File: rtl/lrux_if.sv
// Request and response channel interfaces of the LRU cache.
`default_nettype none

interface lrux_req_if #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
);
   logic                        valid;
   logic                        ready;
   logic [lrux_pkg::CMD_W-1:0]  command;
   logic [KEY_WIDTH-1:0]        key;
   logic [VALUE_WIDTH-1:0]      put_value;

   modport source (output valid, command, key, put_value, input ready);
   modport sink   (input valid, command, key, put_value, output ready);
endinterface

interface lrux_rsp_if #(
   parameter int VALUE_WIDTH = 32,
   parameter int OCC_WIDTH   = 5
);
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [VALUE_WIDTH-1:0] read_value;
   logic [OCC_WIDTH-1:0]   occupancy;
   logic                   evicted;
   logic                   expired_dropped;

   modport source (output valid, hit, read_value, occupancy, evicted, expired_dropped,
                   input ready);
   modport sink   (input valid, hit, read_value, occupancy, evicted, expired_dropped,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/lru_cache_with_expiry.sv
// Top level of the fully associative LRU key-value cache with per-entry expiry.
`default_nettype none

// Fully associative key-value cache of ENTRIES entries kept in a chain of cells
// ordered by recency: cell 0 holds the most recent entry and the valid entries
// fill cells 0 to occupancy-1, so the least recent one is always the last valid
// cell. In the accept cycle each cell compares its key with the request key and
// checks its expiry against the time counter, and registers the outcome; in the
// update cycle the controller decodes the command, tells every cell whether to
// hold, load the new head entry, or take its neighbor's entry, and registers the
// response. A new request is taken while a response still waits in the output
// register; the update cycle waits only when that register is still full.
// Configuration writes take effect at the next edge and are meant to happen
// while no transaction is in flight.
module lru_cache_with_expiry #(
   parameter int ENTRIES     = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   lrux_req_if.sink                            req,
   lrux_rsp_if.source                          rsp,
   input  wire                                 csr_write_enable,
   input  wire [lrux_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [lrux_pkg::CSR_W-1:0]           csr_write_data
);

   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > lrux_pkg::CAP_W) ? OCC_W : lrux_pkg::CAP_W;
   localparam int TIME_W = lrux_pkg::TIME_W;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                  state_ff, state_in;
   logic [lrux_pkg::CMD_W-1:0] cmd_ff;
   logic [KEY_WIDTH-1:0]       key_ff;
   logic [VALUE_WIDTH-1:0]     val_ff;
   logic [lrux_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   logic [TIME_W-1:0]          lifetime_ff, lifetime_in;
   logic [TIME_W-1:0]          time_ff, time_in;
   logic [OCC_W-1:0]           occ_ff, occ_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, hit_in;
   logic [VALUE_WIDTH-1:0]     rsp_read_ff, read_in;
   logic [OCC_W-1:0]           rsp_occ_ff;
   logic                       rsp_evict_ff, ev_in;
   logic                       rsp_drop_ff, xd_in;

   logic                       accept;
   logic                       exec_go;

   lrux_pkg::lrux_lookup_type  lookup;
   lrux_pkg::lrux_stat_type    stat_arr  [ENTRIES];
   logic [KEY_WIDTH-1:0]       key_arr   [ENTRIES];
   logic [VALUE_WIDTH-1:0]     value_arr [ENTRIES];
   logic [TIME_W-1:0]          exp_arr   [ENTRIES];
   lrux_pkg::lrux_move_type    move_arr  [ENTRIES];

   logic [ENTRIES-1:0]         match_vec;
   logic [ENTRIES-1:0]         valid_vec;
   logic [ENTRIES-1:0]         above_vec;
   logic [ENTRIES-1:0]         below_vec;
   logic                       any_match;
   logic                       match_expired;
   logic [VALUE_WIDTH-1:0]     sel_value;
   logic [TIME_W-1:0]          sel_expiry;
   logic                       table_full;
   logic [TIME_W:0]            expiry_sum;
   logic [TIME_W-1:0]          new_expiry;

   logic [VALUE_WIDTH-1:0]     head_value;
   logic [TIME_W-1:0]          head_expiry;
   logic                       op_touch;
   logic                       op_insert;
   logic                       op_drop;
   logic                       op_clear;

   // Handshake.
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp.ready);

   assign lookup.strobe   = accept;
   assign lookup.time_now = time_ff;

   // Cell chain: each cell sees its two neighbors; the ends see empty entries.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic                   prev_valid, next_valid;
      logic [KEY_WIDTH-1:0]   prev_key, next_key;
      logic [VALUE_WIDTH-1:0] prev_value, next_value;
      logic [TIME_W-1:0]      prev_expiry, next_expiry;

      if (i == 0) begin : g_first
         assign prev_valid  = 1'b0;
         assign prev_key    = '0;
         assign prev_value  = '0;
         assign prev_expiry = '0;
      end else begin : g_mid_prev
         assign prev_valid  = stat_arr[i-1].valid;
         assign prev_key    = key_arr[i-1];
         assign prev_value  = value_arr[i-1];
         assign prev_expiry = exp_arr[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign next_valid  = 1'b0;
         assign next_key    = '0;
         assign next_value  = '0;
         assign next_expiry = '0;
      end else begin : g_mid_next
         assign next_valid  = stat_arr[i+1].valid;
         assign next_key    = key_arr[i+1];
         assign next_value  = value_arr[i+1];
         assign next_expiry = exp_arr[i+1];
      end

      lrux_cell #(
         .KEY_WIDTH   (KEY_WIDTH),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .lookup      (lookup),
         .lookup_key  (req.key),
         .move        (move_arr[i]),
         .head_key    (key_ff),
         .head_value  (head_value),
         .head_expiry (head_expiry),
         .prev_valid  (prev_valid),
         .prev_key    (prev_key),
         .prev_value  (prev_value),
         .prev_expiry (prev_expiry),
         .next_valid  (next_valid),
         .next_key    (next_key),
         .next_value  (next_value),
         .next_expiry (next_expiry),
         .stat        (stat_arr[i]),
         .cell_key    (key_arr[i]),
         .cell_value  (value_arr[i]),
         .cell_expiry (exp_arr[i])
      );

      assign match_vec[i] = stat_arr[i].match;
      assign valid_vec[i] = stat_arr[i].valid;
   end

   // Gather the lookup outcome; at most one cell matches.
   always_comb begin
      sel_value     = '0;
      sel_expiry    = '0;
      match_expired = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (stat_arr[i].match) begin
            sel_value     = sel_value | value_arr[i];
            sel_expiry    = sel_expiry | exp_arr[i];
            match_expired = match_expired | stat_arr[i].expired;
         end
         // Cell i lies at or before the hit (above) or at or after it (below).
         above_vec[i] = |(match_vec >> i);
         below_vec[i] = |(match_vec << (ENTRIES - 1 - i));
      end
   end

   assign any_match  = |match_vec;
   assign table_full = (CMP_W'(occ_ff) >= CMP_W'(capacity_ff)) ||
                       (occ_ff == OCC_W'(ENTRIES));

   // Saturating expiry for a stored entry.
   assign expiry_sum = {1'b0, time_ff} + {1'b0, lifetime_ff};
   assign new_expiry = expiry_sum[TIME_W] ? {TIME_W{1'b1}} : expiry_sum[TIME_W-1:0];

   // Command decode for the update cycle.
   always_comb begin
      hit_in      = 1'b0;
      read_in     = '0;
      ev_in       = 1'b0;
      xd_in       = 1'b0;
      occ_in      = occ_ff;
      time_in     = time_ff;
      head_value  = val_ff;
      head_expiry = new_expiry;
      op_touch    = 1'b0;
      op_insert   = 1'b0;
      op_drop     = 1'b0;
      op_clear    = 1'b0;
      if (exec_go) begin
         unique case (cmd_ff)
            lrux_pkg::CMD_PUT: begin
               if (capacity_ff != '0) begin
                  if (any_match) begin
                     op_touch = 1'b1;
                  end else begin
                     op_insert = 1'b1;
                     ev_in     = table_full;
                     if (!table_full) begin
                        occ_in = occ_ff + OCC_W'(1);
                     end
                  end
               end
            end
            lrux_pkg::CMD_GET: begin
               if (any_match) begin
                  if (match_expired) begin
                     op_drop = 1'b1;
                     xd_in   = 1'b1;
                     occ_in  = occ_ff - OCC_W'(1);
                  end else begin
                     op_touch    = 1'b1;
                     hit_in      = 1'b1;
                     read_in     = sel_value;
                     head_value  = sel_value;
                     head_expiry = sel_expiry;
                  end
               end
            end
            lrux_pkg::CMD_REMOVE: begin
               if (any_match) begin
                  op_drop = 1'b1;
                  occ_in  = occ_ff - OCC_W'(1);
               end
            end
            lrux_pkg::CMD_CLEAR: begin
               op_clear = 1'b1;
               occ_in   = '0;
            end
            lrux_pkg::CMD_TICK: begin
               if (time_ff != {TIME_W{1'b1}}) begin
                  time_in = time_ff + TIME_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Per-cell moves: touch and insert shift toward the tail, drop closes the gap.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         move_arr[i] = lrux_pkg::MOVE_HOLD;
         if (op_clear) begin
            move_arr[i] = lrux_pkg::MOVE_CLEAR;
         end else if (op_touch) begin
            if (i == 0) begin
               move_arr[i] = lrux_pkg::MOVE_HEAD;
            end else if (above_vec[i]) begin
               move_arr[i] = lrux_pkg::MOVE_PREV;
            end
         end else if (op_insert) begin
            if (i == 0) begin
               move_arr[i] = lrux_pkg::MOVE_HEAD;
            end else if ((OCC_W'(i) < occ_ff) || ((OCC_W'(i) == occ_ff) && !ev_in)) begin
               move_arr[i] = lrux_pkg::MOVE_PREV;
            end
         end else if (op_drop) begin
            if (below_vec[i]) begin
               move_arr[i] = lrux_pkg::MOVE_NEXT;
            end
         end
      end
   end

   // Configuration register writes.
   always_comb begin
      capacity_in = capacity_ff;
      lifetime_in = lifetime_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            lrux_pkg::CSR_CAPACITY:       capacity_in = csr_write_data[lrux_pkg::CAP_W-1:0];
            lrux_pkg::CSR_DEFAULT_EXPIRY: lifetime_in = csr_write_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lrux_pkg::CAP_RESET;
         lifetime_ff <= lrux_pkg::EXPIRY_RESET;
         time_ff     <= '0;
         occ_ff      <= '0;
      end else begin
         capacity_ff <= capacity_in;
         lifetime_ff <= lifetime_in;
         time_ff     <= time_in;
         occ_ff      <= occ_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req.command;
         key_ff <= req.key;
         val_ff <= req.put_value;
      end
   end

   // Sequencer next state and response valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (exec_go) begin
         rsp_hit_ff   <= hit_in;
         rsp_read_ff  <= read_in;
         rsp_occ_ff   <= occ_in;
         rsp_evict_ff <= ev_in;
         rsp_drop_ff  <= xd_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.hit             = rsp_hit_ff;
   assign rsp.read_value      = rsp_read_ff;
   assign rsp.occupancy       = rsp_occ_ff;
   assign rsp.evicted         = rsp_evict_ff;
   assign rsp.expired_dropped = rsp_drop_ff;

   // Keys are unique among valid cells, so a lookup hits at most one cell.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $onehot0(match_vec))
      else $error("lookup matched more than one cell");

   // The occupancy counter tracks the valid cells.
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == occ_ff)
      else $error("occupancy disagrees with the valid cells");

   // Occupancy stays within the table.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(ENTRIES))
      else $error("occupancy beyond table size");

   // An eviction replaces one entry and leaves the occupancy unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (exec_go && ev_in) |=> (occ_ff == $past(occ_ff)))
      else $error("eviction changed the occupancy");

endmodule

`default_nettype wire

// File: rtl/lrux_cell.sv
// One entry of the recency-ordered chain: compares on lookup and shifts on update.
`default_nettype none

module lrux_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire lrux_pkg::lrux_lookup_type   lookup,
   input  wire [KEY_WIDTH-1:0]              lookup_key,
   input  wire lrux_pkg::lrux_move_type     move,
   input  wire [KEY_WIDTH-1:0]              head_key,
   input  wire [VALUE_WIDTH-1:0]            head_value,
   input  wire [lrux_pkg::TIME_W-1:0]       head_expiry,
   input  wire                              prev_valid,
   input  wire [KEY_WIDTH-1:0]              prev_key,
   input  wire [VALUE_WIDTH-1:0]            prev_value,
   input  wire [lrux_pkg::TIME_W-1:0]       prev_expiry,
   input  wire                              next_valid,
   input  wire [KEY_WIDTH-1:0]              next_key,
   input  wire [VALUE_WIDTH-1:0]            next_value,
   input  wire [lrux_pkg::TIME_W-1:0]       next_expiry,
   output lrux_pkg::lrux_stat_type          stat,
   output logic [KEY_WIDTH-1:0]             cell_key,
   output logic [VALUE_WIDTH-1:0]           cell_value,
   output logic [lrux_pkg::TIME_W-1:0]      cell_expiry
);

   logic                        valid_ff, valid_in;
   logic [KEY_WIDTH-1:0]        key_ff, key_in;
   logic [VALUE_WIDTH-1:0]      value_ff, value_in;
   logic [lrux_pkg::TIME_W-1:0] expiry_ff, expiry_in;
   logic                        match_ff, match_in;
   logic                        expired_ff, expired_in;

   // Lookup flags are captured when a transaction is accepted.
   always_comb begin
      match_in   = match_ff;
      expired_in = expired_ff;
      if (lookup.strobe) begin
         match_in   = valid_ff && (key_ff == lookup_key);
         expired_in = lookup.time_now > expiry_ff;
      end
   end

   // Select the entry this cell holds after the update edge.
   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      expiry_in = expiry_ff;
      case (move)
         lrux_pkg::MOVE_HEAD: begin
            valid_in  = 1'b1;
            key_in    = head_key;
            value_in  = head_value;
            expiry_in = head_expiry;
         end
         lrux_pkg::MOVE_PREV: begin
            valid_in  = prev_valid;
            key_in    = prev_key;
            value_in  = prev_value;
            expiry_in = prev_expiry;
         end
         lrux_pkg::MOVE_NEXT: begin
            valid_in  = next_valid;
            key_in    = next_key;
            value_in  = next_value;
            expiry_in = next_expiry;
         end
         lrux_pkg::MOVE_CLEAR: begin
            valid_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         match_ff   <= 1'b0;
         expired_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         match_ff   <= match_in;
         expired_ff <= expired_in;
      end
   end

   // Entry payload.
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      value_ff  <= value_in;
      expiry_ff <= expiry_in;
   end

   assign stat.valid   = valid_ff;
   assign stat.match   = match_ff;
   assign stat.expired = expired_ff;
   assign cell_key     = key_ff;
   assign cell_value   = value_ff;
   assign cell_expiry  = expiry_ff;

endmodule

`default_nettype wire

// File: tb/lru_cache_with_expiry_checker.sv
// Response checker for the LRU cache: mirrors the cache state and compares every response.
`default_nettype none

module lru_cache_with_expiry_checker #(
   parameter int ENTRIES = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire [lrux_pkg::CMD_W-1:0]          req_command,
   input  wire [31:0]                         req_key,
   input  wire [31:0]                         req_put_value,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire                                rsp_hit,
   input  wire [31:0]                         rsp_read_value,
   input  wire [lrux_pkg::CAP_W-1:0]          rsp_occupancy,
   input  wire                                rsp_evicted,
   input  wire                                rsp_expired_dropped,
   input  wire                                csr_write_enable,
   input  wire [lrux_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [lrux_pkg::CSR_W-1:0]          csr_write_data,
   output int                                 mismatches,
   output int                                 replies_pending
);

   // One response of the cache.
   typedef struct packed {
      logic                       hit;
      logic [31:0]                read_value;
      logic [lrux_pkg::CAP_W-1:0] occupancy;
      logic                       evicted;
      logic                       expired_dropped;
   } cache_reply_type;

   // Mirrored registers and table contents.
   logic [lrux_pkg::CAP_W-1:0]  capacity;
   logic [lrux_pkg::TIME_W-1:0] lifetime;
   logic [31:0]                 key_tbl    [ENTRIES];
   logic [31:0]                 value_tbl  [ENTRIES];
   logic [lrux_pkg::TIME_W-1:0] expiry_tbl [ENTRIES];
   logic                        live       [ENTRIES];
   int                          rank       [ENTRIES];
   logic [lrux_pkg::TIME_W-1:0] now;

   cache_reply_type   replies_q [$];
   cache_reply_type   want;
   int                reply_index;

   task automatic report_mismatch(input string what);
      $display("mismatch at response %0d: %s", reply_index, what);
      mismatches++;
   endtask

   function automatic int live_count();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++) if (live[i]) n++;
      return n;
   endfunction

   function automatic int find_slot(input logic [31:0] key);
      int slot;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (slot < 0 && live[i] && key_tbl[i] == key) slot = i;
      return slot;
   endfunction

   // Move a live entry to the most recent position.
   function automatic void promote(input int slot);
      int r;
      r = rank[slot];
      for (int i = 0; i < ENTRIES; i++) if (live[i] && rank[i] < r) rank[i]++;
      rank[slot] = 0;
   endfunction

   // Invalidate an entry and close the gap it leaves in the recency order.
   function automatic void retire(input int slot);
      int r;
      r = rank[slot];
      live[slot] = 1'b0;
      rank[slot] = 0;
      for (int i = 0; i < ENTRIES; i++) if (live[i] && rank[i] > r) rank[i]--;
   endfunction

   // Apply one command to the mirrored table and return the response it causes.
   function automatic cache_reply_type cache_apply(input logic [lrux_pkg::CMD_W-1:0] command,
                                                   input logic [31:0] key,
                                                   input logic [31:0] value);
      cache_reply_type r;
      int              slot;
      int              lru;
      int              limit;
      int              count;
      logic [32:0]     sum;
      r = '0;
      limit = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
      case (command)
         lrux_pkg::CMD_PUT: begin
            if (limit != 0) begin
               slot = find_slot(key);
               if (slot >= 0) begin
                  promote(slot);
               end else begin
                  // A full table, or one shrunk below its occupancy, loses exactly one entry.
                  if (live_count() >= limit) begin
                     lru = -1;
                     for (int i = 0; i < ENTRIES; i++)
                        if (live[i] && (lru < 0 || rank[i] > rank[lru])) lru = i;
                     if (lru >= 0) begin
                        retire(lru);
                        r.evicted = 1'b1;
                     end
                  end
                  for (int i = 0; i < ENTRIES; i++) if (slot < 0 && !live[i]) slot = i;
                  if (slot >= 0) begin
                     for (int i = 0; i < ENTRIES; i++) if (live[i]) rank[i]++;
                     live[slot] = 1'b1;
                     rank[slot] = 0;
                     key_tbl[slot] = key;
                  end
               end
               if (slot >= 0) begin
                  sum = {1'b0, now} + {1'b0, lifetime};
                  value_tbl[slot] = value;
                  expiry_tbl[slot] = sum[32] ? '1 : sum[31:0];
               end
            end
         end
         lrux_pkg::CMD_GET: begin
            slot = find_slot(key);
            if (slot >= 0) begin
               if (now > expiry_tbl[slot]) begin
                  retire(slot);
                  r.expired_dropped = 1'b1;
               end else begin
                  promote(slot);
                  r.hit = 1'b1;
                  r.read_value = value_tbl[slot];
               end
            end
         end
         lrux_pkg::CMD_REMOVE: begin
            slot = find_slot(key);
            if (slot >= 0) retire(slot);
         end
         lrux_pkg::CMD_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) begin
               live[i] = 1'b0;
               rank[i] = 0;
            end
         end
         lrux_pkg::CMD_TICK: begin
            if (now != '1) now = now + 1'b1;
         end
         default: ;
      endcase
      count = live_count();
      r.occupancy = count[lrux_pkg::CAP_W-1:0];
      return r;
   endfunction

   // Track configuration, predict each request and compare each response.
   always @(posedge clock) begin
      if (reset) begin
         capacity = lrux_pkg::CAP_RESET;
         lifetime = lrux_pkg::EXPIRY_RESET;
         now = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            live[i] = 1'b0;
            rank[i] = 0;
         end
         replies_q.delete();
         reply_index = 0;
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_q.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               want = replies_q.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit got %0b expected %0b", rsp_hit, want.hit));
               if (rsp_read_value !== want.read_value)
                  report_mismatch($sformatf("read_value got %h expected %h",
                                            rsp_read_value, want.read_value));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy got %0d expected %0d",
                                            rsp_occupancy, want.occupancy));
               if (rsp_evicted !== want.evicted)
                  report_mismatch($sformatf("evicted got %0b expected %0b",
                                            rsp_evicted, want.evicted));
               if (rsp_expired_dropped !== want.expired_dropped)
                  report_mismatch($sformatf("expired_dropped got %0b expected %0b",
                                            rsp_expired_dropped, want.expired_dropped));
            end
            reply_index++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               lrux_pkg::CSR_CAPACITY:
                  capacity = csr_write_data[lrux_pkg::CAP_W-1:0];
               lrux_pkg::CSR_DEFAULT_EXPIRY:
                  lifetime = csr_write_data[lrux_pkg::TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            replies_q.push_back(cache_apply(req_command, req_key, req_put_value));
      end
      replies_pending <= replies_q.size();
   end

endmodule

`default_nettype wire

// File: tb/lru_cache_with_expiry_tb.sv
// Top of the LRU cache testbench: clock, reset, stimulus, response pacing and verdict.
`default_nettype none

module lru_cache_with_expiry_tb;

   localparam int POOL_SIZE       = 24;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int CMD_CODE_MAX    = (1 << lrux_pkg::CMD_W) - 1;

   // Register settings of the random phases; the second one shrinks a full table.
   localparam logic [lrux_pkg::CAP_W-1:0] PHASE_CAPACITY [PHASES] = '{
      5'd16, 5'd3, 5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16
   };
   localparam logic [lrux_pkg::TIME_W-1:0] PHASE_LIFETIME [PHASES] = '{
      32'd300, 32'd4, 32'd2, 32'd1, 32'd0, 32'd5, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFF0
   };

   // Raw command code, including the unused ones.
   typedef logic [lrux_pkg::CMD_W-1:0] cmd_code_type;

   // How the response side paces its ready.
   typedef enum logic [1:0] {
      PACE_FREE,
      PACE_RANDOM,
      PACE_PERIODIC,
      PACE_SPARSE
   } rsp_pace_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_enable;
   logic [lrux_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lrux_pkg::CSR_W-1:0]       csr_write_data;
   logic                             accept_rsp = 1'b0;
   rsp_pace_type                     pace = PACE_FREE;
   logic [6:0]                       pace_count = '0;
   int                               idle_cycles = 0;
   int                               mismatch_count;
   int                               replies_pending;
   logic [31:0]                      key_pool [POOL_SIZE];

   lrux_req_if #(.KEY_WIDTH(32), .VALUE_WIDTH(32)) req_ch ();
   lrux_rsp_if #(.VALUE_WIDTH(32), .OCC_WIDTH(lrux_pkg::CAP_W)) rsp_ch ();

   assign rsp_ch.ready = accept_rsp;

   lru_cache_with_expiry u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   lru_cache_with_expiry_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_command         (req_ch.command),
      .req_key             (req_ch.key),
      .req_put_value       (req_ch.put_value),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_hit             (rsp_ch.hit),
      .rsp_read_value      (rsp_ch.read_value),
      .rsp_occupancy       (rsp_ch.occupancy),
      .rsp_evicted         (rsp_ch.evicted),
      .rsp_expired_dropped (rsp_ch.expired_dropped),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .mismatches          (mismatch_count),
      .replies_pending     (replies_pending)
   );

   always #5 clock = ~clock;

   // Response side: a new stall pattern is drawn each time the pace counter wraps.
   always @(posedge clock) begin
      pace_count <= pace_count + 1'b1;
      if (pace_count == '0) pace <= rsp_pace_type'($urandom_range(0, 3));
      case (pace)
         PACE_FREE:     accept_rsp <= 1'b1;
         PACE_RANDOM:   accept_rsp <= ($urandom_range(0, 3) != 0);
         PACE_PERIODIC: accept_rsp <= (pace_count[2:0] == 3'd0);
         default:       accept_rsp <= ($urandom_range(0, 2) == 0);
      endcase
   end

   // End the run when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request and hold it until the cache takes it.
   task automatic send_item(input logic [lrux_pkg::CMD_W-1:0] command,
                            input logic [31:0] key, input logic [31:0] value);
      req_ch.valid     <= 1'b1;
      req_ch.command   <= command;
      req_ch.key       <= key;
      req_ch.put_value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop sending and wait until every outstanding response has come back.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
   endtask

   task automatic write_settings(input logic [lrux_pkg::CAP_W-1:0] capacity,
                                 input logic [lrux_pkg::TIME_W-1:0] lifetime);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_index        <= lrux_pkg::CSR_CAPACITY;
      csr_write_data   <= {{(lrux_pkg::CSR_W - lrux_pkg::CAP_W){1'b0}}, capacity};
      @(posedge clock);
      csr_index        <= lrux_pkg::CSR_DEFAULT_EXPIRY;
      csr_write_data   <= lifetime;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Keys come mostly from a small pool so that lookups hit and entries get replaced.
   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 19) < 17) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom();
   endfunction

   task automatic send_random_item();
      int           roll;
      cmd_code_type command;
      roll = $urandom_range(0, 99);
      if (roll < 36)      command = lrux_pkg::CMD_PUT;
      else if (roll < 72) command = lrux_pkg::CMD_GET;
      else if (roll < 80) command = lrux_pkg::CMD_REMOVE;
      else if (roll < 96) command = lrux_pkg::CMD_TICK;
      else if (roll < 98) command = lrux_pkg::CMD_CLEAR;
      else command = cmd_code_type'($urandom_range(int'(lrux_pkg::CMD_TICK) + 1,
                                                   CMD_CODE_MAX));
      send_item(command, pick_key(), $urandom());
   endtask

   // Random requests in bursts of random length separated by random gaps.
   task automatic run_random_phase(input int items);
      int burst_left;
      int gap;
      burst_left = 0;
      for (int n = 0; n < items; n++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
         end
         send_random_item();
         burst_left--;
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= lrux_pkg::CMD_PUT;
      req_ch.key       <= '0;
      req_ch.put_value <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= lrux_pkg::CSR_CAPACITY;
      csr_write_data   <= '0;
      for (int i = 0; i < POOL_SIZE - 2; i++) key_pool[i] = $urandom();
      key_pool[POOL_SIZE - 2] = '0;
      key_pool[POOL_SIZE - 1] = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Extreme keys and values, update in place, absent remove, unused codes, clear.
      send_item(lrux_pkg::CMD_GET, 32'h0, 32'h0);
      send_item(lrux_pkg::CMD_PUT, 32'h0, 32'hFFFF_FFFF);
      send_item(lrux_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0);
      send_item(lrux_pkg::CMD_GET, 32'h0, 32'h0);
      send_item(lrux_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(lrux_pkg::CMD_PUT, 32'h0, 32'h5A5A_A5A5);
      send_item(lrux_pkg::CMD_GET, 32'h0, 32'h0);
      send_item(lrux_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_item(lrux_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
      for (int c = int'(lrux_pkg::CMD_TICK) + 1; c <= CMD_CODE_MAX; c++)
         send_item(cmd_code_type'(c), 32'h0, 32'hFFFF_FFFF);
      send_item(lrux_pkg::CMD_TICK, 32'h0, 32'h0);
      send_item(lrux_pkg::CMD_CLEAR, 32'h0, 32'h0);
      send_item(lrux_pkg::CMD_GET, 32'h0, 32'h0);

      // Two entries with a lifetime of one tick: eviction, expiry, put on an expired key.
      write_settings(5'd2, 32'd1);
      send_item(lrux_pkg::CMD_PUT, key_pool[0], 32'h1111_1111);
      send_item(lrux_pkg::CMD_PUT, key_pool[1], 32'h2222_2222);
      send_item(lrux_pkg::CMD_PUT, key_pool[2], 32'h3333_3333);
      send_item(lrux_pkg::CMD_GET, key_pool[0], 32'h0);
      send_item(lrux_pkg::CMD_TICK, 32'h0, 32'h0);
      send_item(lrux_pkg::CMD_TICK, 32'h0, 32'h0);
      send_item(lrux_pkg::CMD_GET, key_pool[1], 32'h0);
      send_item(lrux_pkg::CMD_PUT, key_pool[2], 32'h4444_4444);
      send_item(lrux_pkg::CMD_GET, key_pool[2], 32'h0);

      // Zero capacity ignores puts.
      write_settings(5'd0, 32'd0);
      send_item(lrux_pkg::CMD_PUT, key_pool[3], 32'h5555_5555);
      send_item(lrux_pkg::CMD_GET, key_pool[3], 32'h0);

      for (int p = 0; p < PHASES; p++) begin
         write_settings(PHASE_CAPACITY[p], PHASE_LIFETIME[p]);
         run_random_phase(ITEMS_PER_PHASE);
      end

      wait_for_drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
